>>> rtl/dstq_pkg.sv
// Package: shared types, constants and helpers of the timer queue.
package dstq_pkg;

  localparam int TIMER_SLOTS = 8;
  localparam int TICK_WIDTH  = 32;
  localparam int ID_W        = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);

  typedef logic [TICK_WIDTH-1:0] tick_t;

  localparam logic [2:0] OP_SETUP   = 3'd0;
  localparam logic [2:0] OP_START   = 3'd1;
  localparam logic [2:0] OP_RESTART = 3'd2;
  localparam logic [2:0] OP_STOP    = 3'd3;
  localparam logic [2:0] OP_TICK    = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  timer_id;
    logic [31:0] period;
    logic        periodic;
  } cmd_t;

  typedef struct packed {
    logic [2:0] fired_id;
    logic       last_fired;
  } result_t;

  // One queue entry held by a cell.
  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
    tick_t           expiry;
  } entry_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic            remove;
    logic            insert;
    logic            pop;
    logic [ID_W-1:0] rm_id;
    entry_t          new_ent;
  } cell_ctrl_t;

  // a is before b, wrap-safe.
  function automatic logic tick_before(input tick_t a, input tick_t b);
    tick_t d;
    d = a - b;
    return d[TICK_WIDTH-1];
  endfunction

  function automatic tick_t norm_period(input tick_t p);
    return (p == '0) ? tick_t'(1) : p;
  endfunction

endpackage

>>> rtl/deadline_sorted_timer_queue_top.sv
// Top level: sorted timer queue built as a chain of entry cells plus a sequencer.
//
//  channel | signals            | handshake
//  --------+--------------------+-------------------------------------------
//  command | start, cmd, busy   | beat taken when start & !busy
//  result  | strobe, result     | one-cycle beat when strobe, cannot stall
//
// Steps: set up and stop run a remove pass, start and restart a remove pass,
// then an insert pass through the cell chain. A tick checks the head and
// pops each fired timer; a fired periodic timer is popped, then re-inserted.
// The chain moves one entry step per cycle, so one queue edit per cycle sets
// the pace.
// Reset: synchronous, clears the queue, tick counter and slot tables.
// The last result of a tick leaves with last_fired set, in the cycle busy drops.
module deadline_sorted_timer_queue_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  dstq_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              strobe,
  output dstq_pkg::result_t result
);

  localparam int N = dstq_pkg::TIMER_SLOTS;

  typedef enum logic [2:0] {ST_IDLE, ST_RM, ST_INS, ST_TCHK, ST_RS} state_t;

  state_t                      state;
  dstq_pkg::tick_t             cur_tick;
  dstq_pkg::tick_t             period_store [N];
  logic [N-1:0]                periodic_flag;
  logic                        ins_pend;
  logic [dstq_pkg::ID_W-1:0]   op_id;
  dstq_pkg::tick_t             ins_exp;
  dstq_pkg::tick_t             rs_sum;
  dstq_pkg::tick_t             rs_alt;
  logic [dstq_pkg::CNT_W-1:0]  fire_cnt;
  logic                        pend;
  logic [dstq_pkg::ID_W-1:0]   pend_id;

  dstq_pkg::cell_ctrl_t        ctrl;
  dstq_pkg::entry_t            ents [N];
  logic [N:0]                  rm_c;
  logic [N:0]                  go_c;
  dstq_pkg::entry_t            empty_ent;

  dstq_pkg::entry_t            head;
  dstq_pkg::tick_t             head_d;
  logic                        head_due;
  dstq_pkg::tick_t             in_period;
  dstq_pkg::tick_t             head_p;
  logic                        id_ok;

  assign empty_ent = '0;
  assign rm_c[0]   = 1'b0;
  assign go_c[0]   = 1'b0;

  // chain of cells, entry 0 is the queue head
  for (genvar i = 0; i < N; i++) begin : g_cell
    dstq_pkg::entry_t lft;
    dstq_pkg::entry_t rgt;
    if (i == 0) begin : g_l0
      assign lft = empty_ent;
    end else begin : g_l
      assign lft = ents[i-1];
    end
    if (i == N - 1) begin : g_rn
      assign rgt = empty_ent;
    end else begin : g_r
      assign rgt = ents[i+1];
    end
    dstq_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl),
      .left   (lft),
      .right  (rgt),
      .rm_in  (rm_c[i]),
      .rm_out (rm_c[i+1]),
      .go_in  (go_c[i]),
      .go_out (go_c[i+1]),
      .ent    (ents[i])
    );
  end

  assign busy      = (state != ST_IDLE);
  assign head      = ents[0];
  assign head_d    = head.expiry - cur_tick;
  assign head_due  = head.valid && ((head_d == '0) || head_d[dstq_pkg::TICK_WIDTH-1])
                     && (fire_cnt < dstq_pkg::CNT_W'(N));
  assign in_period = dstq_pkg::norm_period(dstq_pkg::tick_t'(cmd.period));
  assign head_p    = dstq_pkg::norm_period(period_store[head.id]);
  assign id_ok     = ({1'b0, cmd.timer_id} < 4'(N));

  // cell commands decoded from the sequencer state
  always_comb begin
    ctrl         = '0;
    ctrl.rm_id   = op_id;
    ctrl.new_ent = '{valid: 1'b1, id: op_id, expiry: ins_exp};
    case (state)
      ST_RM:   ctrl.remove = 1'b1;
      ST_INS:  ctrl.insert = 1'b1;
      ST_TCHK: ctrl.pop    = head_due;
      ST_RS: begin
        ctrl.insert         = 1'b1;
        ctrl.new_ent.expiry = dstq_pkg::tick_before(rs_sum, cur_tick) ? rs_alt : rs_sum;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cur_tick      <= '0;
      periodic_flag <= '0;
      strobe        <= 1'b0;
      pend          <= 1'b0;
      fire_cnt      <= '0;
      ins_pend      <= 1'b0;
      for (int k = 0; k < N; k++) period_store[k] <= '0;
    end else begin
      strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            op_id    <= cmd.timer_id[dstq_pkg::ID_W-1:0];
            ins_pend <= 1'b0;
            if (cmd.op == dstq_pkg::OP_TICK) begin
              cur_tick <= cur_tick + dstq_pkg::tick_t'(1);
              fire_cnt <= '0;
              pend     <= 1'b0;
              state    <= ST_TCHK;
            end else if (id_ok) begin
              case (cmd.op)
                dstq_pkg::OP_SETUP: begin
                  period_store[cmd.timer_id[dstq_pkg::ID_W-1:0]]  <= in_period;
                  periodic_flag[cmd.timer_id[dstq_pkg::ID_W-1:0]] <= cmd.periodic;
                  state <= ST_RM;
                end
                dstq_pkg::OP_START: begin
                  ins_exp  <= cur_tick + dstq_pkg::norm_period(
                                period_store[cmd.timer_id[dstq_pkg::ID_W-1:0]]);
                  ins_pend <= 1'b1;
                  state    <= ST_RM;
                end
                dstq_pkg::OP_RESTART: begin
                  period_store[cmd.timer_id[dstq_pkg::ID_W-1:0]] <= in_period;
                  ins_exp  <= cur_tick + in_period;
                  ins_pend <= 1'b1;
                  state    <= ST_RM;
                end
                dstq_pkg::OP_STOP: state <= ST_RM;
                default: ;
              endcase
            end
          end
        end
        ST_RM:  state <= ins_pend ? ST_INS : ST_IDLE;
        ST_INS: state <= ST_IDLE;
        ST_TCHK: begin
          if (head_due) begin
            // the previous fired timer is not the last one
            if (pend) begin
              strobe            <= 1'b1;
              result.fired_id   <= 3'(pend_id);
              result.last_fired <= 1'b0;
            end
            pend     <= 1'b1;
            pend_id  <= head.id;
            fire_cnt <= fire_cnt + dstq_pkg::CNT_W'(1);
            if (periodic_flag[head.id]) begin
              op_id  <= head.id;
              rs_sum <= head.expiry + head_p;
              rs_alt <= cur_tick + head_p;
              state  <= ST_RS;
            end
          end else begin
            if (pend) begin
              strobe            <= 1'b1;
              result.fired_id   <= 3'(pend_id);
              result.last_fired <= 1'b1;
            end
            pend  <= 1'b0;
            state <= ST_IDLE;
          end
        end
        ST_RS: state <= ST_TCHK;
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/dstq_cell.sv
// One cell of the sorted queue: holds an entry, shifts toward either neighbor.
module dstq_cell (
  input  logic                clk,
  input  logic                rst,
  input  dstq_pkg::cell_ctrl_t ctrl,
  input  dstq_pkg::entry_t    left,
  input  dstq_pkg::entry_t    right,
  input  logic                rm_in,
  output logic                rm_out,
  input  logic                go_in,
  output logic                go_out,
  output dstq_pkg::entry_t    ent
);

  dstq_pkg::entry_t ent_next;
  logic match;
  logic go;

  assign match  = ent.valid && (ent.id == ctrl.rm_id);
  assign rm_out = rm_in | match;
  // new entry lands before the first cell that is empty or expires later
  assign go     = !ent.valid || dstq_pkg::tick_before(ctrl.new_ent.expiry, ent.expiry);
  assign go_out = go_in | go;

  always_comb begin
    ent_next = ent;
    if (ctrl.pop) begin
      ent_next = right;
    end else if (ctrl.remove) begin
      if (rm_out) ent_next = right;
    end else if (ctrl.insert) begin
      if (go_in) ent_next = left;
      else if (go) ent_next = ctrl.new_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent.valid <= ent_next.valid;
    end
    ent.id     <= ent_next.id;
    ent.expiry <= ent_next.expiry;
  end

endmodule
